[rtl/lcpc_pkg.sv]
// ----------------------------------------------------------------------------
// lcpc_pkg
// Shared types and constants of the loop current pressure conditioner.
// ----------------------------------------------------------------------------
package lcpc_pkg;

  // default parameter values
  localparam int ADC_BITS_DEF    = 10;
  localparam int MAX_SAMPLES_DEF = 1024;

  // fixed field widths
  localparam int CUR_W    = 16;  // loop current, 1/256 mA
  localparam int GAIN_W   = 24;  // current gain, 2^-24 mA per count
  localparam int FGAIN_W  = 17;  // filter coefficient, 2^-16
  localparam int SLOPE_W  = 24;  // pressure slope, 2^-16 MPa per mA
  localparam int PRES_W   = 32;  // pressure, 2^-16 MPa
  localparam int CFG_W    = 32;  // configuration write data
  localparam int CFG_IDX_W = 3;  // configuration register index

  // filter coefficient of one, the largest legal value
  localparam logic [FGAIN_W-1:0] FGAIN_ONE = FGAIN_W'(65536);

  // register reset values
  localparam logic [GAIN_W-1:0]         CURRENT_GAIN_RST = GAIN_W'(327680);
  localparam logic [FGAIN_W-1:0]        FILTER_GAIN_RST  = FGAIN_ONE;
  localparam logic signed [SLOPE_W-1:0] SLOPE_RST        = SLOPE_W'(40960);
  localparam logic signed [PRES_W-1:0]  INTERCEPT_RST    = -32'sd163840;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURRENT_GAIN       = 3'd0,
    REG_FILTER_GAIN        = 3'd1,
    REG_DUMMY_ENABLE       = 3'd2,
    REG_DUMMY_CURRENT      = 3'd3,
    REG_OFFSET_CURRENT     = 3'd4,
    REG_PRESSURE_SLOPE     = 3'd5,
    REG_PRESSURE_INTERCEPT = 3'd6
  } cfg_reg_t;

  // read sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,  // taking items
    ST_GAIN,  // sum times current gain
    ST_DIV,   // divide by sample count
    ST_FILT,  // filter load or start of filter product
    ST_FMUL,  // filter product
    ST_PRES,  // start of pressure product
    ST_PMUL   // pressure product, then result
  } state_t;

endpackage

[rtl/lcpc_in_if.sv]
// ----------------------------------------------------------------------------
// lcpc_in_if
// Input channel: sample and read items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcpc_in_if #(
  parameter int ADC_BITS = lcpc_pkg::ADC_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                mode;
  logic [ADC_BITS-1:0] adc_value;
  logic                select_raw;

  modport source (output valid, output mode, output adc_value, output select_raw,
                  input ready);
  modport sink (input valid, input mode, input adc_value, input select_raw,
                output ready);
endinterface

[rtl/lcpc_out_if.sv]
// ----------------------------------------------------------------------------
// lcpc_out_if
// Output channel: current and pressure result items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lcpc_out_if;
  logic                                valid;
  logic                                ready;
  logic [lcpc_pkg::CUR_W-1:0]          current_out;
  logic signed [lcpc_pkg::PRES_W-1:0]  pressure_out;
  logic                                had_samples;

  modport source (output valid, output current_out, output pressure_out,
                  output had_samples, input ready);
  modport sink (input valid, input current_out, input pressure_out,
                input had_samples, output ready);
endinterface

[rtl/lcpc_serial_mul.sv]
// ----------------------------------------------------------------------------
// lcpc_serial_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module lcpc_serial_mul #(
  parameter int AW = 34,
  parameter int BW = lcpc_pkg::GAIN_W
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [AW-1:0] a,
  input  logic [BW-1:0]        b,
  input  logic                 b_signed,
  output logic                 done,
  output logic signed [AW+BW-1:0] product
);
  localparam int PW = AW + BW;
  localparam int CW = (BW > 1) ? $clog2(BW) : 1;

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic signed [PW-1:0] mcand;
  logic [BW-1:0]        mplier;
  logic                 sign_mode;
  logic signed [PW-1:0] acc;
  logic signed [PW-1:0] addend;
  logic signed [PW-1:0] acc_next;
  logic                 last;

  // one partial product per cycle, the top bit weighs negative when signed
  always_comb begin
    last     = (cnt == CW'(BW - 1));
    addend   = mplier[0] ? mcand : '0;
    acc_next = (last && sign_mode) ? acc - addend : acc + addend;
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (last) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand shift registers and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      mcand     <= PW'(a);
      mplier    <= b;
      sign_mode <= b_signed;
      acc       <= '0;
    end else if (busy) begin
      mcand  <= mcand <<< 1;
      mplier <= mplier >> 1;
      acc    <= acc_next;
    end
  end

  assign product = acc;

endmodule

[rtl/lcpc_serial_div.sv]
// ----------------------------------------------------------------------------
// lcpc_serial_div
// Restoring divider giving floor(n / (d * 2^QW)) saturated to QW bits,
// one quotient bit per cycle after a single overflow check.
// ----------------------------------------------------------------------------
module lcpc_serial_div #(
  parameter int NW = 57,
  parameter int DW = 11,
  parameter int QW = lcpc_pkg::CUR_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quotient
);
  localparam int SH = 2 * QW;
  localparam int CW = $clog2(QW + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [NW-1:0] rem;
  logic [NW-1:0] dvs;
  logic          fits;
  logic          check;
  logic          finish;

  // check step compares against d * 2^(2*QW); later steps produce one bit
  always_comb begin
    fits   = (rem >= dvs);
    check  = (cnt == '0);
    finish = busy && ((check && fits) || (cnt == CW'(QW)));
  end

  // step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CW'(1);
        if (finish) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder, shifted divisor and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dvs      <= NW'(divisor) << SH;
      quotient <= '0;
    end else if (busy) begin
      dvs <= dvs >> 1;
      if (check) begin
        if (fits) begin
          quotient <= '1;
        end
      end else begin
        if (fits) begin
          rem <= rem - dvs;
        end
        quotient <= {quotient[QW-2:0], fits};
      end
    end
  end

endmodule

[rtl/loop_current_pressure_conditioner.sv]
// ----------------------------------------------------------------------------
// loop_current_pressure_conditioner
// 4-20 mA loop sensor front end: sample averaging, low-pass filter, pressure.
// ----------------------------------------------------------------------------
// in_ch carries items: mode 0 adds an adc_value sample to the accumulator,
// mode 1 is a read that produces exactly one result item on out_ch
// (current_out, pressure_out, had_samples). Samples make no result.
// Configuration is written over cfg_we / cfg_index / cfg_data; the user
// must write it only while idle, the block does not enforce this. Samples
// are taken one per cycle while no read is in progress. A read runs on one
// shared bit-serial multiplier and a bit-serial divider: a read that
// averages samples runs the gain, divide, filter and pressure steps; a read
// without new samples or in dummy mode skips gain and divide. The first read
// after reset skips the filter product. in_ch.ready is low during a read.
// The result sits in an output register; a stalled receiver holds it while
// further samples are taken, and only a following read waits for it to drain
// before its pressure product starts.
// Reset restores the register defaults, clears the accumulator and currents,
// and makes the first read load the filter directly.
// ----------------------------------------------------------------------------
module loop_current_pressure_conditioner #(
  parameter int ADC_BITS    = lcpc_pkg::ADC_BITS_DEF,
  parameter int MAX_SAMPLES = lcpc_pkg::MAX_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  lcpc_in_if.sink                           in_ch,
  lcpc_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [lcpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lcpc_pkg::CFG_W-1:0]        cfg_data
);
  localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W   = ADC_BITS + CNT_W;
  localparam int PROD_W  = SUM_W + lcpc_pkg::GAIN_W;
  localparam int MUL_AW  = (SUM_W + 1 > lcpc_pkg::SLOPE_W) ? SUM_W + 1 : lcpc_pkg::SLOPE_W;
  localparam int MUL_BW  = lcpc_pkg::GAIN_W;
  localparam int MUL_PW  = MUL_AW + MUL_BW;
  localparam int CUR_W   = lcpc_pkg::CUR_W;
  localparam int PRES_W  = lcpc_pkg::PRES_W;
  localparam int FSUM_W  = 2 * CUR_W + 2;
  localparam int PSUM_W  = PRES_W + 3;

  // configuration registers
  logic [lcpc_pkg::GAIN_W-1:0]         current_gain;
  logic [lcpc_pkg::FGAIN_W-1:0]        filter_gain;
  logic                                dummy_enable;
  logic [CUR_W-1:0]                    dummy_current;
  logic signed [CUR_W-1:0]             offset_current;
  logic signed [lcpc_pkg::SLOPE_W-1:0] pressure_slope;
  logic signed [PRES_W-1:0]            pressure_intercept;

  // block state
  lcpc_pkg::state_t   state;
  lcpc_pkg::state_t   state_next;
  logic [SUM_W-1:0]   sample_sum;
  logic [CNT_W-1:0]   sample_count;
  logic [CUR_W-1:0]   raw_current;
  logic [CUR_W-1:0]   filtered_current;
  logic               filter_primed;
  logic               select_raw;
  logic               had_samples;

  // output register
  logic                    out_valid;
  logic [CUR_W-1:0]        current_out;
  logic signed [PRES_W-1:0] pressure_out;
  logic                    out_had;

  // arithmetic units
  logic                     mul_start;
  logic signed [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0]        mul_b;
  logic                     mul_b_signed;
  logic                     mul_done;
  logic signed [MUL_PW-1:0] mul_product;
  logic                     div_start;
  logic                     div_done;
  logic [CUR_W-1:0]         div_quotient;

  // datapath helpers
  logic                      in_fire;
  logic                      out_fire;
  logic                      read_fire;
  logic                      use_samples;
  logic signed [CUR_W:0]     filt_diff;
  logic signed [CUR_W+1:0]   offset_ext;
  logic signed [CUR_W+1:0]   eff;
  logic signed [FSUM_W-1:0]  filt_sum;
  logic [CUR_W-1:0]          filt_new;
  logic signed [PSUM_W-1:0]  pres_sum;
  logic signed [PRES_W-1:0]  pres_sat;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_valid && out_ch.ready;
  assign read_fire   = in_fire && in_ch.mode;
  assign use_samples = !dummy_enable && (sample_count != '0);

  assign in_ch.ready         = (state == lcpc_pkg::ST_IDLE);
  assign out_ch.valid        = out_valid;
  assign out_ch.current_out  = current_out;
  assign out_ch.pressure_out = pressure_out;
  assign out_ch.had_samples  = out_had;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      current_gain       <= lcpc_pkg::CURRENT_GAIN_RST;
      filter_gain        <= lcpc_pkg::FILTER_GAIN_RST;
      dummy_enable       <= 1'b0;
      dummy_current      <= '0;
      offset_current     <= '0;
      pressure_slope     <= lcpc_pkg::SLOPE_RST;
      pressure_intercept <= lcpc_pkg::INTERCEPT_RST;
    end else if (cfg_we) begin
      unique case (lcpc_pkg::cfg_reg_t'(cfg_index))
        lcpc_pkg::REG_CURRENT_GAIN: begin
          current_gain <= cfg_data[lcpc_pkg::GAIN_W-1:0];
        end
        lcpc_pkg::REG_FILTER_GAIN: begin
          // zero or above one keeps the old coefficient
          if (cfg_data[lcpc_pkg::FGAIN_W-1:0] != '0 &&
              cfg_data[lcpc_pkg::FGAIN_W-1:0] <= lcpc_pkg::FGAIN_ONE) begin
            filter_gain <= cfg_data[lcpc_pkg::FGAIN_W-1:0];
          end
        end
        lcpc_pkg::REG_DUMMY_ENABLE: begin
          dummy_enable <= cfg_data[0];
        end
        lcpc_pkg::REG_DUMMY_CURRENT: begin
          dummy_current <= cfg_data[CUR_W-1:0];
        end
        lcpc_pkg::REG_OFFSET_CURRENT: begin
          offset_current <= cfg_data[CUR_W-1:0];
        end
        lcpc_pkg::REG_PRESSURE_SLOPE: begin
          pressure_slope <= cfg_data[lcpc_pkg::SLOPE_W-1:0];
        end
        lcpc_pkg::REG_PRESSURE_INTERCEPT: begin
          pressure_intercept <= cfg_data[PRES_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // filter step and pressure result from the shared product
  always_comb begin
    filt_diff  = $signed({1'b0, raw_current}) - $signed({1'b0, filtered_current});
    offset_ext = dummy_enable ? '0 : (CUR_W+2)'(offset_current);
    eff        = $signed({2'b00, filtered_current}) - offset_ext;
    filt_sum   = $signed({2'b00, filtered_current, {CUR_W{1'b0}}}) + FSUM_W'(mul_product);
    filt_new   = filt_sum[2*CUR_W-1:CUR_W];
    pres_sum   = PSUM_W'(mul_product >>> 8) + PSUM_W'(pressure_intercept);
    if (pres_sum[PSUM_W-1:PRES_W-1] == '0 || pres_sum[PSUM_W-1:PRES_W-1] == '1) begin
      pres_sat = pres_sum[PRES_W-1:0];
    end else if (pres_sum[PSUM_W-1]) begin
      pres_sat = {1'b1, {(PRES_W-1){1'b0}}};
    end else begin
      pres_sat = {1'b0, {(PRES_W-1){1'b1}}};
    end
  end

  // read sequencer
  always_comb begin
    state_next   = state;
    mul_start    = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    mul_b_signed = 1'b0;
    div_start    = 1'b0;
    unique case (state)
      lcpc_pkg::ST_IDLE: begin
        mul_a = MUL_AW'({1'b0, sample_sum});
        mul_b = current_gain;
        if (read_fire) begin
          if (use_samples) begin
            mul_start  = 1'b1;
            state_next = lcpc_pkg::ST_GAIN;
          end else begin
            state_next = lcpc_pkg::ST_FILT;
          end
        end
      end
      lcpc_pkg::ST_GAIN: begin
        if (mul_done) begin
          div_start  = 1'b1;
          state_next = lcpc_pkg::ST_DIV;
        end
      end
      lcpc_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = lcpc_pkg::ST_FILT;
        end
      end
      lcpc_pkg::ST_FILT: begin
        mul_a = MUL_AW'(filt_diff);
        mul_b = MUL_BW'(filter_gain);
        if (filter_primed) begin
          mul_start  = 1'b1;
          state_next = lcpc_pkg::ST_FMUL;
        end else begin
          state_next = lcpc_pkg::ST_PRES;
        end
      end
      lcpc_pkg::ST_FMUL: begin
        if (mul_done) begin
          state_next = lcpc_pkg::ST_PRES;
        end
      end
      lcpc_pkg::ST_PRES: begin
        mul_a        = MUL_AW'(pressure_slope);
        mul_b        = MUL_BW'(eff);
        mul_b_signed = 1'b1;
        // wait for the output register to drain before the last product
        if (!out_valid) begin
          mul_start  = 1'b1;
          state_next = lcpc_pkg::ST_PMUL;
        end
      end
      lcpc_pkg::ST_PMUL: begin
        if (mul_done) begin
          state_next = lcpc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = lcpc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lcpc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // accumulator, currents and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum       <= '0;
      sample_count     <= '0;
      raw_current      <= '0;
      filtered_current <= '0;
      filter_primed    <= 1'b0;
    end else begin
      if (in_fire && !in_ch.mode) begin
        if (!dummy_enable && sample_count < CNT_W'(MAX_SAMPLES)) begin
          sample_sum   <= sample_sum + SUM_W'(in_ch.adc_value);
          sample_count <= sample_count + CNT_W'(1);
        end
      end
      if (read_fire && dummy_enable) begin
        raw_current <= dummy_current;
      end
      if (state == lcpc_pkg::ST_DIV && div_done) begin
        raw_current  <= div_quotient;
        sample_sum   <= '0;
        sample_count <= '0;
      end
      if (state == lcpc_pkg::ST_FILT && !filter_primed) begin
        filtered_current <= raw_current;
        filter_primed    <= 1'b1;
      end
      if (state == lcpc_pkg::ST_FMUL && mul_done) begin
        filtered_current <= filt_new;
      end
    end
  end

  // read options captured with the item
  always_ff @(posedge clk) begin
    if (read_fire) begin
      select_raw  <= in_ch.select_raw;
      had_samples <= use_samples;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == lcpc_pkg::ST_PMUL && mul_done) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (state == lcpc_pkg::ST_PMUL && mul_done) begin
      current_out  <= select_raw ? raw_current : filtered_current;
      pressure_out <= pres_sat;
      out_had      <= had_samples;
    end
  end

  lcpc_serial_mul #(
    .AW (MUL_AW),
    .BW (MUL_BW)
  ) u_mul (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_start),
    .a        (mul_a),
    .b        (mul_b),
    .b_signed (mul_b_signed),
    .done     (mul_done),
    .product  (mul_product)
  );

  lcpc_serial_div #(
    .NW (PROD_W),
    .DW (CNT_W),
    .QW (CUR_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mul_product[PROD_W-1:0]),
    .divisor  (sample_count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // samples in dummy mode leave the accumulator alone
  a_dummy_hold: assert property (@(posedge clk) disable iff (rst)
    in_fire && !in_ch.mode && dummy_enable |=> $stable(sample_sum) && $stable(sample_count))
    else $error("accumulator changed on a sample item in dummy mode");

  // accumulator never counts past its limit
  a_count_limit: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_W'(MAX_SAMPLES))
    else $error("sample count above limit");

  // a result appears only at the end of the pressure product
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == lcpc_pkg::ST_PMUL)
    else $error("result item raised outside the pressure step");

  // the divider finishes only while the sequencer waits for it
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == lcpc_pkg::ST_DIV)
    else $error("divider finished outside the divide step");

endmodule

[verif/loop_current_pressure_conditioner_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// loop_current_pressure_conditioner_test
// Self-checking bench for the loop current pressure conditioner. A queue-fed
// driver offers sample and read items with random gaps, and a clocked monitor
// takes result items with random stalls. Every accepted read is run through a
// bit-accurate fixed-point copy of the averaging, filter and pressure math.
// Each result is checked against the oldest predicted reading. Register
// settings are changed between quiet phases and cover the extremes.
// ----------------------------------------------------------------------------
module loop_current_pressure_conditioner_test;
  import lcpc_pkg::*;

  localparam int ADC_W        = ADC_BITS_DEF;
  localparam int SAMPLE_LIMIT = MAX_SAMPLES_DEF;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 400;

  localparam logic MODE_SAMPLE  = 1'b0;
  localparam logic MODE_READ    = 1'b1;
  localparam logic SEL_FILTERED = 1'b0;
  localparam logic SEL_RAW      = 1'b1;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_INDEX = 3'd7;

  localparam longint PRES_MAX = 64'sd2147483647;
  localparam longint PRES_MIN = -64'sd2147483648;

  typedef struct packed {
    logic             mode;
    logic [ADC_W-1:0] adc_value;
    logic             select_raw;
  } conditioner_item_t;

  typedef struct packed {
    logic [CUR_W-1:0]         current_out;
    logic signed [PRES_W-1:0] pressure_out;
    logic                     had_samples;
  } reading_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  lcpc_in_if #(.ADC_BITS(ADC_W)) in_ch ();
  lcpc_out_if out_ch ();

  loop_current_pressure_conditioner #(
    .ADC_BITS(ADC_W),
    .MAX_SAMPLES(SAMPLE_LIMIT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  conditioner_item_t pending_items[$];
  reading_t awaited_readings[$];
  reading_t want;
  int error_count = 0;
  int in_gap;
  int out_gap;
  int hold_left = 0;
  logic steady = 1'b0;

  // mirrored register settings
  logic [GAIN_W-1:0]         cfg_current_gain;
  logic [FGAIN_W-1:0]        cfg_filter_gain;
  logic                      cfg_dummy_enable;
  logic [CUR_W-1:0]          cfg_dummy_current;
  logic signed [CUR_W-1:0]   cfg_offset;
  logic signed [SLOPE_W-1:0] cfg_slope;
  logic signed [PRES_W-1:0]  cfg_intercept;

  // mirrored accumulator and currents
  logic [19:0]      acc_sum;
  logic [10:0]      acc_count;
  logic [CUR_W-1:0] raw_cur;
  logic [CUR_W-1:0] filt_cur;
  logic             filt_primed;

  always #5 clk = ~clk;

  // averaging, filter and pressure for one accepted item
  function automatic void update_conditioner(conditioner_item_t it);
    reading_t r;
    logic [63:0] scaled;
    logic [63:0] blend;
    longint eff;
    longint prod;
    longint pres;
    r.had_samples = 1'b0;
    if (it.mode == MODE_SAMPLE) begin
      if (!cfg_dummy_enable && acc_count < SAMPLE_LIMIT) begin
        acc_sum = acc_sum + it.adc_value;
        acc_count = acc_count + 1;
      end
      return;
    end
    if (cfg_dummy_enable) begin
      raw_cur = cfg_dummy_current;
    end else if (acc_count != 0) begin
      scaled = ((64'(acc_sum) * 64'(cfg_current_gain)) / 64'(acc_count)) >> 16;
      raw_cur = (scaled > 64'd65535) ? 16'hFFFF : scaled[15:0];
      acc_sum = '0;
      acc_count = '0;
      r.had_samples = 1'b1;
    end
    // first read loads the filter directly
    if (!filt_primed) begin
      filt_cur = raw_cur;
      filt_primed = 1'b1;
    end else begin
      blend = (64'(filt_cur) * (64'd65536 - 64'(cfg_filter_gain)) +
               64'(raw_cur) * 64'(cfg_filter_gain)) >> 16;
      filt_cur = blend[15:0];
    end
    // pressure, offset skipped in dummy mode, floor on the scale shift
    eff = longint'(filt_cur);
    if (!cfg_dummy_enable) eff = eff - longint'(cfg_offset);
    prod = longint'(cfg_slope) * eff;
    pres = (prod >>> 8) + longint'(cfg_intercept);
    if (pres > PRES_MAX) pres = PRES_MAX;
    if (pres < PRES_MIN) pres = PRES_MIN;
    r.pressure_out = pres[31:0];
    r.current_out = it.select_raw ? raw_cur : filt_cur;
    awaited_readings.push_back(r);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        update_conditioner(pending_items.pop_front());
        in_gap = steady ? 0 : $urandom_range(0, 3);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_ch.valid <= 1'b0;
          in_gap--;
        end else if (pending_items.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.mode <= pending_items[0].mode;
          in_ch.adc_value <= pending_items[0].adc_value;
          in_ch.select_raw <= pending_items[0].select_raw;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (hold_left > 0) hold_left <= hold_left - 1;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_readings.size() == 0) begin
          $display("%0t: unexpected result cur=%0d pres=%0d had=%0b", $time,
                   out_ch.current_out, out_ch.pressure_out, out_ch.had_samples);
          error_count++;
        end else begin
          want = awaited_readings.pop_front();
          if (out_ch.current_out !== want.current_out ||
              out_ch.pressure_out !== want.pressure_out ||
              out_ch.had_samples !== want.had_samples) begin
            $display("%0t: mismatch expected cur=%0d pres=%0d had=%0b, actual cur=%0d pres=%0d had=%0b",
                     $time, want.current_out, want.pressure_out, want.had_samples,
                     out_ch.current_out, out_ch.pressure_out, out_ch.had_samples);
            error_count++;
          end
        end
        out_gap = steady ? 0 : $urandom_range(0, 3);
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_ch.ready <= 1'b0;
        out_gap--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic push_item(input logic mode, input logic [ADC_W-1:0] adc,
                           input logic sel);
    conditioner_item_t it;
    it.mode = mode;
    it.adc_value = adc;
    it.select_raw = sel;
    pending_items.push_back(it);
  endtask

  task automatic push_sample();
    push_item(MODE_SAMPLE, ADC_W'($urandom_range(0, 1023)), 1'($urandom));
  endtask

  task automatic push_read();
    push_item(MODE_READ, ADC_W'($urandom_range(0, 1023)), 1'($urandom));
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_CURRENT_GAIN: cfg_current_gain = value[GAIN_W-1:0];
      REG_FILTER_GAIN: begin
        // out-of-range coefficient keeps the old one
        if (value[FGAIN_W-1:0] >= 1 && value[FGAIN_W-1:0] <= 65536)
          cfg_filter_gain = value[FGAIN_W-1:0];
      end
      REG_DUMMY_ENABLE: cfg_dummy_enable = value[0];
      REG_DUMMY_CURRENT: cfg_dummy_current = value[CUR_W-1:0];
      REG_OFFSET_CURRENT: cfg_offset = value[CUR_W-1:0];
      REG_PRESSURE_SLOPE: cfg_slope = value[SLOPE_W-1:0];
      REG_PRESSURE_INTERCEPT: cfg_intercept = value[PRES_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_settings(input logic [CFG_W-1:0] gain, input logic [CFG_W-1:0] fgain,
                                  input logic [CFG_W-1:0] dummy, input logic [CFG_W-1:0] dcur,
                                  input logic [CFG_W-1:0] offset, input logic [CFG_W-1:0] slope,
                                  input logic [CFG_W-1:0] icpt);
    write_register(REG_CURRENT_GAIN, gain);
    write_register(REG_FILTER_GAIN, fgain);
    write_register(REG_DUMMY_ENABLE, dummy);
    write_register(REG_DUMMY_CURRENT, dcur);
    write_register(REG_OFFSET_CURRENT, offset);
    write_register(REG_PRESSURE_SLOPE, slope);
    write_register(REG_PRESSURE_INTERCEPT, icpt);
  endtask

  // sample bursts closed by a read, mixed with stray items and bare reads
  task automatic queue_traffic(input int n_items);
    int issued;
    int burst;
    int roll;
    issued = 0;
    @(negedge clk);
    while (issued < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        push_item(1'($urandom), ADC_W'($urandom_range(0, 1023)), 1'($urandom));
        issued++;
      end else if (roll < 18) begin
        push_read();
        issued++;
      end else begin
        burst = $urandom_range(1, 12);
        repeat (burst) push_sample();
        push_read();
        issued += burst + 1;
      end
    end
  endtask

  // wait until everything offered is taken and every reading is back
  task automatic wait_until_quiet();
    while (pending_items.size() != 0 || in_ch.valid || awaited_readings.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_SAMPLE;
    in_ch.adc_value = '0;
    in_ch.select_raw = SEL_FILTERED;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_CURRENT_GAIN;
    cfg_data = '0;
    cfg_current_gain = CURRENT_GAIN_RST;
    cfg_filter_gain = FILTER_GAIN_RST;
    cfg_dummy_enable = 1'b0;
    cfg_dummy_current = '0;
    cfg_offset = '0;
    cfg_slope = SLOPE_RST;
    cfg_intercept = INTERCEPT_RST;
    acc_sum = '0;
    acc_count = '0;
    raw_cur = '0;
    filt_cur = '0;
    filt_primed = 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: first read with nothing averaged, extremes, repeated read
    push_item(MODE_READ, ADC_W'(1023), SEL_FILTERED);
    push_item(MODE_SAMPLE, ADC_W'(0), SEL_RAW);
    push_item(MODE_SAMPLE, ADC_W'(1023), SEL_FILTERED);
    push_item(MODE_READ, ADC_W'(0), SEL_RAW);
    push_item(MODE_READ, ADC_W'(1023), SEL_RAW);
    repeat (3) push_item(MODE_SAMPLE, ADC_W'(1023), SEL_RAW);
    push_item(MODE_READ, ADC_W'(0), SEL_FILTERED);
    push_item(MODE_SAMPLE, ADC_W'(341), SEL_FILTERED);
    push_item(MODE_SAMPLE, ADC_W'(682), SEL_RAW);
    push_item(MODE_READ, ADC_W'(341), SEL_RAW);
    push_item(MODE_SAMPLE, ADC_W'(0), SEL_FILTERED);
    push_item(MODE_READ, ADC_W'(682), SEL_FILTERED);
    push_item(MODE_SAMPLE, ADC_W'(512), SEL_FILTERED);
    push_item(MODE_READ, ADC_W'(0), SEL_RAW);
    wait_until_quiet();

    // reset settings, receiver blocked for a while so the input backs up
    hold_left = HOLD_CYCLES;
    queue_traffic(120);
    wait_until_quiet();

    // overfull accumulator: samples past the limit are dropped
    repeat (1030) push_sample();
    push_read();
    wait_until_quiet();

    // high extremes, then rejected filter gains and the spare index
    program_settings(32'd16777215, 32'd1, 32'd0, 32'd0, -32'sd32768, 32'sd8388607,
                     32'sd2147483647);
    write_register(REG_FILTER_GAIN, 32'd0);
    write_register(REG_FILTER_GAIN, 32'd65537);
    write_register(REG_SPARE_INDEX, $urandom());
    steady = 1'b1;
    queue_traffic(100);
    wait_until_quiet();
    steady = 1'b0;

    // low extremes
    program_settings(32'd1, 32'd65536, 32'd0, 32'd0, 32'sd32767, -32'sd8388608,
                     -32'sd2147483648);
    queue_traffic(100);
    wait_until_quiet();

    // dummy mode at full and at zero current
    program_settings(32'($urandom_range(1, 16777215)), 32'($urandom_range(1, 65536)), 32'd1,
                     32'd65535, 32'($urandom_range(0, 65535)), 32'sd40960, -32'sd163840);
    queue_traffic(60);
    wait_until_quiet();
    write_register(REG_DUMMY_CURRENT, 32'd0);
    queue_traffic(40);
    wait_until_quiet();

    // random settings
    for (int p = 0; p < 3; p++) begin
      program_settings(32'($urandom_range(1, 16777215)), 32'($urandom_range(1, 65536)),
                       32'd0, 32'($urandom_range(0, 65535)), 32'($urandom_range(0, 65535)),
                       32'($urandom_range(0, 16777215)),
                       (p == 0) ? $urandom() : 32'($urandom_range(0, 4194304)) - 32'd2097152);
      steady = (p == 1);
      queue_traffic(100);
      wait_until_quiet();
    end
    steady = 1'b0;

    if (error_count == 0 && awaited_readings.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
